### sv/rotate_through_carry_unit_top_assert.svh
// ----------------------------------------------------------------------------
// rotate through carry unit assertion macros
// shared property shorthands for the blocks that check themselves
// ----------------------------------------------------------------------------
`ifndef ROTATE_THROUGH_CARRY_UNIT_TOP_ASSERT_SVH
`define ROTATE_THROUGH_CARRY_UNIT_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RTCU_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("rtcu assertion failed");

// next-cycle implication, disabled in reset
`define RTCU_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("rtcu assertion failed");

`endif

### sv/rtcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu package
// shared types and constants of the rotate through carry unit
// ----------------------------------------------------------------------------
package rtcu_pkg;

  typedef enum logic [1:0] {
    WC_BYTE  = 2'd0,
    WC_WORD  = 2'd1,
    WC_DWORD = 2'd2,
    WC_QWORD = 2'd3
  } width_code_t;

  localparam logic OP_RCL = 1'b0;
  localparam logic OP_RCR = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // one classified request between front and back
  typedef struct packed {
    logic        right;
    logic [1:0]  width_code;
    logic [6:0]  lamt;        // left rotate amount on the width+1 ring
    logic [63:0] val;         // operand, masked to width
    logic        carry_in;
    logic        overflow_in;
    logic        wr_cf;
    logic        wr_of;
  } entry_t;

endpackage

### sv/rtcu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu input channel
// valid/ready channel carrying one rotate request
// ----------------------------------------------------------------------------
interface rtcu_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [1:0]  width_code;
  logic [7:0]  count;
  logic [63:0] operand;
  logic        carry_in;
  logic        overflow_in;

  modport source (output valid, op, width_code, count, operand, carry_in, overflow_in,
                  input ready);
  modport sink (input valid, op, width_code, count, operand, carry_in, overflow_in,
                output ready);
endinterface

### sv/rtcu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu output channel
// valid/ready channel carrying one rotate result
// ----------------------------------------------------------------------------
interface rtcu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        carry_out;
  logic        overflow_out;

  modport source (output valid, result, carry_out, overflow_out, input ready);
  modport sink (input valid, result, carry_out, overflow_out, output ready);
endinterface

### sv/rtcu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu front
// accepts requests, masks count and operand, reduces the count mod width+1
// ----------------------------------------------------------------------------
module rtcu_front (
  rtcu_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output rtcu_pkg::entry_t push_entry
);

  logic [5:0] cnt;
  logic [5:0] steps;
  logic [6:0] ring_len;
  logic [63:0] val_mask;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    cnt      = (in_ch.width_code == rtcu_pkg::WC_QWORD) ? in_ch.count[5:0]
                                                        : {1'b0, in_ch.count[4:0]};
    steps    = cnt;
    ring_len = 7'd65;
    val_mask = '1;
    case (rtcu_pkg::width_code_t'(in_ch.width_code))
      rtcu_pkg::WC_BYTE: begin
        ring_len = 7'd9;
        val_mask = 64'h0000_0000_0000_00ff;
        // count is at most 31, so at most three subtractions of 9
        if (cnt >= 6'd27) steps = cnt - 6'd27;
        else if (cnt >= 6'd18) steps = cnt - 6'd18;
        else if (cnt >= 6'd9) steps = cnt - 6'd9;
      end
      rtcu_pkg::WC_WORD: begin
        ring_len = 7'd17;
        val_mask = 64'h0000_0000_0000_ffff;
        if (cnt >= 6'd17) steps = cnt - 6'd17;
      end
      rtcu_pkg::WC_DWORD: begin
        ring_len = 7'd33;
        val_mask = 64'h0000_0000_ffff_ffff;
      end
      default: begin
        ring_len = 7'd65;
        val_mask = '1;
      end
    endcase
  end

  always_comb begin
    push_entry.right       = in_ch.op;
    push_entry.width_code  = in_ch.width_code;
    // a right rotate by s is a left rotate by ring_len - s
    push_entry.lamt        = (in_ch.op == rtcu_pkg::OP_RCR && steps != 6'd0)
                             ? (ring_len - {1'b0, steps}) : {1'b0, steps};
    push_entry.val         = in_ch.operand & val_mask;
    push_entry.carry_in    = in_ch.carry_in;
    push_entry.overflow_in = in_ch.overflow_in;
    push_entry.wr_cf       = (cnt != 6'd0);
    push_entry.wr_of       = (cnt == 6'd1);
  end

endmodule

### sv/rtcu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu queue
// two-entry fifo decoupling the front from the back
// ----------------------------------------------------------------------------
`include "rotate_through_carry_unit_top_assert.svh"

module rtcu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rtcu_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output rtcu_pkg::entry_t head
);

  rtcu_pkg::entry_t entries [rtcu_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'(rtcu_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  `RTCU_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= 2'(rtcu_pkg::QUEUE_DEPTH))
  `RTCU_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, fill != 2'd0)
  `RTCU_ASSERT_NOW(a_push_room, clk, rst, push, fill != 2'(rtcu_pkg::QUEUE_DEPTH))

endmodule

### sv/rtcu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu back
// ring rotate of operand and carry, flag update, registered result
// ----------------------------------------------------------------------------
`include "rotate_through_carry_unit_top_assert.svh"

module rtcu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  rtcu_pkg::entry_t head,
  output logic             pop,
  rtcu_out_if.source       out_ch
);

  logic [6:0]  ring_len;
  logic [64:0] ring_mask;
  logic [64:0] ring;
  logic [64:0] ring_rot;
  logic [63:0] val_mask;
  logic [63:0] new_val;
  logic        new_c;
  logic        msb;
  logic        msb_m1;
  logic        carry_next;
  logic        overflow_next;

  always_comb begin
    ring_len = 7'd65;
    val_mask = '1;
    case (rtcu_pkg::width_code_t'(head.width_code))
      rtcu_pkg::WC_BYTE: begin
        ring_len = 7'd9;
        val_mask = 64'h0000_0000_0000_00ff;
      end
      rtcu_pkg::WC_WORD: begin
        ring_len = 7'd17;
        val_mask = 64'h0000_0000_0000_ffff;
      end
      rtcu_pkg::WC_DWORD: begin
        ring_len = 7'd33;
        val_mask = 64'h0000_0000_ffff_ffff;
      end
      default: begin
        ring_len = 7'd65;
        val_mask = '1;
      end
    endcase
  end

  // ring is {carry, val} packed into the low ring_len bits
  always_comb begin
    ring_mask = (65'd1 << ring_len) - 65'd1;
    ring      = {1'b0, head.val} | ({64'd0, head.carry_in} << (ring_len - 7'd1));
    ring_rot  = ((ring << head.lamt) | (ring >> (ring_len - head.lamt))) & ring_mask;
    new_val   = ring_rot[63:0] & val_mask;
  end

  always_comb begin
    case (rtcu_pkg::width_code_t'(head.width_code))
      rtcu_pkg::WC_BYTE: begin
        new_c  = ring_rot[8];
        msb    = new_val[7];
        msb_m1 = new_val[6];
      end
      rtcu_pkg::WC_WORD: begin
        new_c  = ring_rot[16];
        msb    = new_val[15];
        msb_m1 = new_val[14];
      end
      rtcu_pkg::WC_DWORD: begin
        new_c  = ring_rot[32];
        msb    = new_val[31];
        msb_m1 = new_val[30];
      end
      default: begin
        new_c  = ring_rot[64];
        msb    = new_val[63];
        msb_m1 = new_val[62];
      end
    endcase
    carry_next    = head.wr_cf ? new_c : head.carry_in;
    overflow_next = head.overflow_in;
    if (head.wr_of) begin
      overflow_next = (head.right == rtcu_pkg::OP_RCR) ? (msb ^ msb_m1) : (msb ^ new_c);
    end
  end

  assign pop = q_valid && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (pop) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.result       <= new_val;
      out_ch.carry_out    <= carry_next;
      out_ch.overflow_out <= overflow_next;
    end
  end

  `RTCU_ASSERT_NEXT(a_pop_shows, clk, rst, pop, out_ch.valid)
  `RTCU_ASSERT_NEXT(a_zero_rot_holds, clk, rst, pop && head.lamt == 7'd0,
                    out_ch.result == $past(head.val))
  `RTCU_ASSERT_NEXT(a_cf_kept, clk, rst, pop && !head.wr_cf,
                    out_ch.carry_out == $past(head.carry_in))

endmodule

### sv/rotate_through_carry_unit_top.sv
// a request accepted is written into a queue entry, then into the result register when the back pops it
// throughput: one request per cycle while the output takes each result; the ring rotator in the back is combinational
// a two-entry queue lets requests be accepted while a result waits to be taken
// reset: synchronous, active high; clears queue pointers and result valid, no clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate through carry unit top
// x86 rcl/rcr on 8, 16, 32 or 64 bit operands with carry and overflow update
// ----------------------------------------------------------------------------
module rotate_through_carry_unit_top (
  input  logic        clk,
  input  logic        rst,
  rtcu_in_if.sink     in_ch,
  rtcu_out_if.source  out_ch
);

  // front to queue
  logic             push;
  rtcu_pkg::entry_t push_entry;

  // queue to back
  logic             q_full;
  logic             q_valid;
  logic             pop;
  rtcu_pkg::entry_t head;

  // front: masks the count per width, reduces it mod width+1 and
  // turns a right rotate into the matching left ring rotate
  rtcu_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // queue: lets the front keep accepting while the back is stalled, until the queue is full
  rtcu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (head)
  );

  // back: barrel rotate of {carry, operand}, flag writes, result register
  rtcu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
